FILE: rtl/gtf_pkg.sv
package gtf_pkg;

	localparam int ELEMENT_COUNT = 1024;
	localparam int TEAM_COUNT    = 16;
	localparam int QUEUE_DEPTH   = 1024;

	localparam int ELEM_W  = 10;
	localparam int TEAM_W  = 4;
	localparam int NODE_W  = 10;
	localparam int CNT_W   = 11;
	localparam int TCNT_W  = 5;

	typedef enum logic [1:0] {
		MODE_ASSIGN = 2'd0,
		MODE_ENQ    = 2'd1,
		MODE_DEQ    = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_EMPTY  = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_NOTEAM = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_ENQ,
		BK_DEQ
	} bk_state_t;

	typedef struct packed {
		mode_t              mode;
		logic [ELEM_W-1:0]  element;
		logic [TEAM_W-1:0]  team;
	} cmd_t;

	typedef struct packed {
		logic [ELEM_W-1:0]  element;
		status_t            status;
	} res_t;

endpackage

FILE: rtl/gtf_front.sv
module gtf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic                        hold,
	output logic                        full,
	input  logic [1:0]                  mode,
	input  logic [gtf_pkg::ELEM_W-1:0]  element,
	input  logic [gtf_pkg::TEAM_W-1:0]  team,
	output logic                        cmd_valid,
	output gtf_pkg::cmd_t               cmd,
	input  logic                        cmd_pop
);
	import gtf_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       acc;
	cmd_t       cls;

	// classify the incoming transaction into an operation code
	always_comb begin
		cls.mode    = mode_t'(mode);
		cls.element = element;
		cls.team    = team;
	end

	assign full      = (cnt_q == 2'd2) || hold;
	assign acc       = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc)
				wr_q <= !wr_q;
			if (cmd_pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			slot_q[wr_q] <= cls;
	end

endmodule

FILE: rtl/gtf_resq.sv
module gtf_resq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        res_push,
	input  gtf_pkg::res_t               res,
	output logic                        room,
	output logic                        empty,
	input  logic                        pop,
	output logic [gtf_pkg::ELEM_W-1:0]  dequeued_element,
	output logic [1:0]                  status
);
	import gtf_pkg::*;

	res_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       take;

	assign room             = (cnt_q != 2'd2);
	assign empty            = (cnt_q == 2'd0);
	assign take             = pop && !empty;
	assign dequeued_element = slot_q[rd_q].element;
	assign status           = slot_q[rd_q].status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (res_push)
				wr_q <= !wr_q;
			if (take)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(res_push) - 2'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (res_push)
			slot_q[wr_q] <= res;
	end

endmodule

FILE: rtl/gtf_back.sv
module gtf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  gtf_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	input  logic           res_room,
	output logic           res_push,
	output gtf_pkg::res_t  res,
	output logic           clearing
);
	import gtf_pkg::*;

	bk_state_t state_q, state_d;

	// memories
	logic [TEAM_W:0]   mem_team [ELEMENT_COUNT];
	logic [ELEM_W-1:0] mem_elem [QUEUE_DEPTH];
	logic [NODE_W-1:0] mem_next [QUEUE_DEPTH];
	logic [NODE_W-1:0] mem_free [QUEUE_DEPTH];

	logic [TEAM_W:0]   team_rd_s1;
	logic [NODE_W-1:0] free_rd_s1;
	logic [ELEM_W-1:0] elem_rd_s1;
	logic [NODE_W-1:0] next_rd_s1;

	// line of teams
	logic [TEAM_COUNT-1:0] waiting_q;
	logic [NODE_W-1:0]     first_q [TEAM_COUNT];
	logic [NODE_W-1:0]     last_q  [TEAM_COUNT];
	logic [TEAM_W-1:0]     order_q [TEAM_COUNT];
	logic [TEAM_W-1:0]     head_q;
	logic [TCNT_W-1:0]     count_q;

	// node allocation: untouched nodes from fresh_q upward, returned nodes on a stack
	logic [CNT_W-1:0]  fresh_q;
	logic [CNT_W-1:0]  stk_q;

	logic [ELEM_W-1:0] clr_idx_q;
	logic              clr_res_q;

	cmd_t              cmd_s1;
	logic [TEAM_W-1:0] t_s1;
	logic [NODE_W-1:0] node_s1;

	logic [TEAM_W-1:0] head_team;
	logic [NODE_W-1:0] head_node;
	logic [TEAM_W-1:0] enq_team;
	logic              enq_full;
	logic [NODE_W-1:0] enq_node;
	logic              start;
	logic              clr_last;
	logic              enq_ok;
	logic              deq_go;
	logic              do_assign;
	logic              do_clear;

	assign head_team = order_q[head_q];
	assign head_node = first_q[head_team];
	assign enq_team  = team_rd_s1[TEAM_W-1:0];
	assign enq_full  = (fresh_q == CNT_W'(QUEUE_DEPTH)) && (stk_q == '0);
	assign enq_node  = (stk_q != '0) ? free_rd_s1 : fresh_q[NODE_W-1:0];
	assign start     = (state_q == BK_IDLE) && cmd_valid && res_room;
	assign clr_last  = (clr_idx_q == ELEM_W'(ELEMENT_COUNT - 1));
	assign clearing  = (state_q == BK_CLEAR);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLEAR: begin
				if (clr_last)
					state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (start) begin
					unique case (cmd.mode)
						MODE_ASSIGN: state_d = BK_IDLE;
						MODE_ENQ:    state_d = BK_ENQ;
						MODE_DEQ:    state_d = (count_q == '0) ? BK_IDLE : BK_DEQ;
						MODE_CLEAR:  state_d = BK_CLEAR;
						default:     state_d = BK_IDLE;
					endcase
				end
			end
			BK_ENQ:  state_d = BK_IDLE;
			BK_DEQ:  state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop     = 1'b0;
		res_push    = 1'b0;
		res.element = '0;
		res.status  = STAT_OK;
		enq_ok      = 1'b0;
		deq_go      = 1'b0;
		do_assign   = 1'b0;
		do_clear    = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				res_push = clr_last && clr_res_q;
			end
			BK_IDLE: begin
				if (start) begin
					cmd_pop = 1'b1;
					unique case (cmd.mode)
						MODE_ASSIGN: begin
							do_assign = 1'b1;
							res_push  = 1'b1;
						end
						MODE_DEQ: begin
							if (count_q == '0) begin
								res_push   = 1'b1;
								res.status = STAT_EMPTY;
							end else begin
								deq_go = 1'b1;
							end
						end
						MODE_CLEAR: do_clear = 1'b1;
						default: ;
					endcase
				end
			end
			BK_ENQ: begin
				res_push = 1'b1;
				if (!team_rd_s1[TEAM_W])
					res.status = STAT_NOTEAM;
				else if (enq_full)
					res.status = STAT_FULL;
				else
					enq_ok = 1'b1;
			end
			BK_DEQ: begin
				res_push    = 1'b1;
				res.element = elem_rd_s1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			clr_idx_q <= '0;
			clr_res_q <= 1'b0;
			fresh_q   <= '0;
			stk_q     <= '0;
			waiting_q <= '0;
			head_q    <= '0;
			count_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR)
				clr_idx_q <= clr_idx_q + 1'b1;
			if (do_clear) begin
				clr_idx_q <= '0;
				clr_res_q <= 1'b1;
				fresh_q   <= '0;
				stk_q     <= '0;
				waiting_q <= '0;
				head_q    <= '0;
				count_q   <= '0;
			end
			if (enq_ok) begin
				if (stk_q != '0)
					stk_q <= stk_q - 1'b1;
				else
					fresh_q <= fresh_q + 1'b1;
				if (!waiting_q[enq_team]) begin
					waiting_q[enq_team] <= 1'b1;
					count_q             <= count_q + 1'b1;
				end
			end
			if (state_q == BK_DEQ) begin
				stk_q <= stk_q + 1'b1;
				if (node_s1 == last_q[t_s1]) begin
					waiting_q[t_s1] <= 1'b0;
					head_q          <= head_q + 1'b1;
					count_q         <= count_q - 1'b1;
				end
			end
		end
	end

	// team chain ends, latched operands
	always_ff @(posedge clk) begin
		if (start) begin
			cmd_s1  <= cmd;
			t_s1    <= head_team;
			node_s1 <= head_node;
		end
		if (enq_ok) begin
			last_q[enq_team] <= enq_node;
			if (!waiting_q[enq_team]) begin
				first_q[enq_team]                       <= enq_node;
				order_q[head_q + count_q[TEAM_W-1:0]]   <= enq_team;
			end
		end
		if ((state_q == BK_DEQ) && (node_s1 != last_q[t_s1]))
			first_q[t_s1] <= next_rd_s1;
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_CLEAR)
			mem_team[clr_idx_q] <= '0;
		else if (do_assign)
			mem_team[cmd.element] <= {1'b1, cmd.team};
		team_rd_s1 <= mem_team[cmd.element];
	end

	always_ff @(posedge clk) begin
		if (enq_ok)
			mem_elem[enq_node] <= cmd_s1.element;
		elem_rd_s1 <= mem_elem[head_node];
	end

	always_ff @(posedge clk) begin
		if (enq_ok && waiting_q[enq_team])
			mem_next[last_q[enq_team]] <= enq_node;
		next_rd_s1 <= mem_next[head_node];
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_DEQ)
			mem_free[stk_q[NODE_W-1:0]] <= node_s1;
		free_rd_s1 <= mem_free[stk_q[NODE_W-1:0] - 1'b1];
	end

endmodule

FILE: rtl/grouped_team_fifo_unit.sv
// An assign, or a dequeue of an empty line, is answered from the back end's idle state;
// an enqueue or any other dequeue is answered from BK_ENQ or BK_DEQ after its reads.
// Throughput: one assign per cycle while the result queue has room; an enqueue or dequeue
// holds the back end in BK_ENQ or BK_DEQ before it takes another command, set by the
// read-then-write of the node and membership memories. A clear sweeps the 1024-entry
// membership memory; reset starts the same sweep, and full stays high for its duration.
module grouped_team_fifo_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  mode,
	input  logic [gtf_pkg::ELEM_W-1:0]  element,
	input  logic [gtf_pkg::TEAM_W-1:0]  team,
	output logic                        empty,
	input  logic                        pop,
	output logic [gtf_pkg::ELEM_W-1:0]  dequeued_element,
	output logic [1:0]                  status
);
	import gtf_pkg::*;

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	logic res_room;
	logic res_push;
	res_t res;
	logic clearing;

	gtf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.hold      (clearing),
		.full      (full),
		.mode      (mode),
		.element   (element),
		.team      (team),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	gtf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_room  (res_room),
		.res_push  (res_push),
		.res       (res),
		.clearing  (clearing)
	);

	gtf_resq u_resq (
		.clk              (clk),
		.arst_n           (arst_n),
		.res_push         (res_push),
		.res              (res),
		.room             (res_room),
		.empty            (empty),
		.pop              (pop),
		.dequeued_element (dequeued_element),
		.status           (status)
	);

endmodule

FILE: rtl/gtf_checker.sv
module gtf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [9:0] dequeued_element,
	input logic [1:0] status
);
	import gtf_pkg::*;

	// no transaction in or out while held in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> empty && full)
		else $error("transaction possible during reset");

	// a failed transaction carries no element
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (status != STAT_OK) |-> dequeued_element == '0)
		else $error("failed transaction carries an element");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("waiting result withdrawn");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(dequeued_element) && $stable(status))
		else $error("waiting result changed");

endmodule

bind grouped_team_fifo_unit gtf_checker u_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.full             (full),
	.empty            (empty),
	.pop              (pop),
	.dequeued_element (dequeued_element),
	.status           (status)
);

FILE: tb/sv/grouped_team_fifo_unit_tb.sv
module grouped_team_fifo_unit_tb;
	import gtf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [1:0] mode = MODE_ASSIGN;
	logic [ELEM_W-1:0] element = '0;
	logic [TEAM_W-1:0] team = '0;
	logic full, empty;
	logic [ELEM_W-1:0] dequeued_element;
	logic [1:0] status;

	grouped_team_fifo_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.mode(mode), .element(element), .team(team),
		.empty(empty), .pop(pop), .dequeued_element(dequeued_element), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state: membership plus one queue of elements per team and a line of teams
	logic              member_valid [ELEMENT_COUNT];
	logic [TEAM_W-1:0] member_team [ELEMENT_COUNT];
	logic [ELEM_W-1:0] team_line [TEAM_COUNT][$];
	logic [TEAM_W-1:0] team_order [$];
	int                waiting_total;

	typedef struct {
		logic [ELEM_W-1:0] element;
		status_t           status;
	} outcome_t;
	outcome_t pending_outcomes [$];

	int  mismatches = 0;
	int  cycle_count = 0;
	int  pop_stall = 0;
	bit  idle_allowed = 1'b1;
	logic [ELEM_W-1:0] rand_pool [8];

	function automatic void clear_membership();
		for (int i = 0; i < ELEMENT_COUNT; i++) begin
			member_valid[i] = 1'b0;
			member_team[i] = '0;
		end
		for (int t = 0; t < TEAM_COUNT; t++)
			team_line[t].delete();
		team_order.delete();
		waiting_total = 0;
	endfunction

	function automatic outcome_t predict_transaction(mode_t m, logic [ELEM_W-1:0] e,
			logic [TEAM_W-1:0] t);
		outcome_t o;
		logic [TEAM_W-1:0] front;
		o.element = '0;
		o.status = STAT_OK;
		case (m)
			MODE_ASSIGN: begin
				member_valid[e] = 1'b1;
				member_team[e] = t;
			end
			MODE_ENQ: begin
				if (!member_valid[e])
					o.status = STAT_NOTEAM;
				else if (waiting_total == QUEUE_DEPTH)
					o.status = STAT_FULL;
				else begin
					if (team_line[member_team[e]].size() == 0)
						team_order.insert(team_order.size(), member_team[e]);
					team_line[member_team[e]].insert(team_line[member_team[e]].size(), e);
					waiting_total++;
				end
			end
			MODE_DEQ: begin
				if (team_order.size() == 0)
					o.status = STAT_EMPTY;
				else begin
					front = team_order[0];
					o.element = team_line[front].pop_front();
					waiting_total--;
					if (team_line[front].size() == 0)
						void'(team_order.pop_front());
				end
			end
			default: clear_membership();
		endcase
		return o;
	endfunction

	task automatic send_transaction(mode_t m, logic [ELEM_W-1:0] e, logic [TEAM_W-1:0] t);
		if (idle_allowed && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		push <= 1'b1;
		mode <= m;
		element <= e;
		team <= t;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_outcomes.insert(pending_outcomes.size(), predict_transaction(m, e, t));
	endtask

	// result side: random pop stalls, compare each transaction with the oldest expectation
	always @(posedge clk) begin
		outcome_t exp_o;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_outcomes.size() == 0) begin
					$display("%0t: unexpected result element=%0d status=%0d", $realtime,
						dequeued_element, status);
					mismatches++;
				end else begin
					exp_o = pending_outcomes.pop_front();
					if (dequeued_element !== exp_o.element || status !== exp_o.status) begin
						$display("%0t: expected element=%0d status=%0d, actual element=%0d status=%0d",
							$realtime, exp_o.element, exp_o.status, dequeued_element, status);
						mismatches++;
					end
				end
			end
			// stall the result side in random bursts
			if (pop_stall > 0) begin
				pop <= 1'b0;
				pop_stall--;
			end else if (idle_allowed && $urandom_range(0, 4) == 0) begin
				pop <= 1'b0;
				pop_stall = $urandom_range(0, 4);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic drain_results();
		push <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_transaction(MODE_DEQ, 10'd0, 4'd0);
		send_transaction(MODE_ENQ, 10'd5, 4'd0);
		send_transaction(MODE_ASSIGN, 10'd0, 4'd0);
		send_transaction(MODE_ASSIGN, 10'd1023, 4'd15);
		send_transaction(MODE_ASSIGN, 10'd5, 4'd3);
		send_transaction(MODE_ENQ, 10'd0, 4'd0);
		send_transaction(MODE_ENQ, 10'd1023, 4'd0);
		send_transaction(MODE_ENQ, 10'd5, 4'd0);
		send_transaction(MODE_ENQ, 10'd0, 4'd0);
		send_transaction(MODE_ASSIGN, 10'd0, 4'd15); // reassign; queued copy stays put
		send_transaction(MODE_ENQ, 10'd0, 4'd0);
		send_transaction(MODE_ENQ, 10'd0, 4'd0);     // duplicate copy
		repeat (7) send_transaction(MODE_DEQ, 10'd0, 4'd0);
		send_transaction(MODE_ENQ, 10'd5, 4'd0);
		send_transaction(MODE_CLEAR, 10'h3ff, 4'hf);
		send_transaction(MODE_ENQ, 10'd5, 4'd0);
		send_transaction(MODE_DEQ, 10'd0, 4'd0);
	endtask

	task automatic test_full_line();
		send_transaction(MODE_ASSIGN, 10'd7, 4'd9);
		send_transaction(MODE_ASSIGN, 10'd8, 4'd2);
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_transaction(MODE_ENQ, (i % 3 == 0) ? 10'd8 : 10'd7, 4'd0);
		send_transaction(MODE_ENQ, 10'd7, 4'd0);
		send_transaction(MODE_ENQ, 10'd300, 4'd0); // no team beats full
		// hold until everything has come back
		drain_results();
		send_transaction(MODE_CLEAR, 10'd0, 4'd0);
	endtask

	task automatic test_random(int count);
		mode_t m;
		logic [ELEM_W-1:0] e;
		for (int i = 0; i < 8; i++)
			rand_pool[i] = ELEM_W'($urandom);
		for (int i = 0; i < count; i++) begin
			if (i == count - 150)
				idle_allowed = 1'b0;
			e = ($urandom_range(0, 9) == 0) ? ELEM_W'($urandom) : rand_pool[$urandom_range(0, 7)];
			case ($urandom_range(0, 19))
				0, 1, 2, 3: m = MODE_ASSIGN;
				19:         m = ($urandom_range(0, 9) == 0) ? MODE_CLEAR : MODE_DEQ;
				4, 5, 6, 7, 8, 9, 10: m = MODE_DEQ;
				default:    m = MODE_ENQ;
			endcase
			send_transaction(m, e, TEAM_W'($urandom));
		end
	endtask

	initial begin
		clear_membership();
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_line();
		test_random(200);
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: grouped_team_fifo_unit.f
rtl/gtf_pkg.sv
rtl/gtf_front.sv
rtl/gtf_resq.sv
rtl/gtf_back.sv
rtl/grouped_team_fifo_unit.sv
rtl/gtf_checker.sv
tb/sv/grouped_team_fifo_unit_tb.sv
